>>> src/gti_pkg.sv
// Shared constants and handshake types for the grid trilinear interpolator.
package gti_pkg;

   // Fixed-point formats
   localparam int unsigned DataWidth = 32;
   localparam int unsigned FracWidth = 17;
   localparam logic [FracWidth-1:0] FracOne  = 17'h10000;
   localparam logic [FracWidth-1:0] FracHalf = 17'h08000;

   // Parameter defaults and fixed limits
   localparam int unsigned AxisMaxDefault   = 16;
   localparam int unsigned ValuesMaxDefault = 8;
   localparam int unsigned QueryMax         = 8;
   localparam int unsigned AxisCount        = 3;

   // Item modes
   localparam logic [1:0] ModeAxisLoad  = 2'd0;
   localparam logic [1:0] ModeValueLoad = 2'd1;
   localparam logic [1:0] ModeQuery     = 2'd2;

   // Register indexes
   localparam logic [2:0] CsrQueryLinear = 3'd0;
   localparam logic [2:0] CsrSpaceDim    = 3'd1;
   localparam logic [2:0] CsrCountX      = 3'd2;
   localparam logic [2:0] CsrCountY      = 3'd3;
   localparam logic [2:0] CsrCountZ      = 3'd4;
   localparam logic [2:0] CsrValueCount  = 3'd5;
   localparam logic [2:0] CsrQueryCount  = 3'd6;
   localparam logic [2:0] CsrQueryMap    = 3'd7;

   // Divider request and response
   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FracWidth-2:0] quo;
   } div_rsp_type;

endpackage

>>> src/gti_div.sv
// Bit-serial restoring divider giving the Q0.16 fraction num * 2^16 / den, num < den.
module gti_div (
   input  logic                clock,
   input  logic                reset,
   input  gti_pkg::div_req_type div_req,
   output gti_pkg::div_rsp_type div_rsp
);
   import gti_pkg::*;

   localparam int unsigned Steps = FracWidth - 1;

   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [Steps-1:0] quo_ff, quo_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [32:0]      shifted;

   // One quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, 1'b0};
      if (div_req.start) begin
         rem_in = div_req.num;
         den_in = div_req.den;
         quo_in = '0;
         cnt_in = 5'(Steps);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 32'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[Steps-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[Steps-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

>>> src/gti_lerp.sv
// Shared lerp unit: a + (b - a) * f, round half up, one register after the multiply.
module gti_lerp (
   input  logic                                  clock,
   input  logic signed [gti_pkg::DataWidth-1:0] lerp_a,
   input  logic signed [gti_pkg::DataWidth-1:0] lerp_b,
   input  logic        [gti_pkg::FracWidth-1:0] lerp_f,
   output logic signed [gti_pkg::DataWidth-1:0] lerp_y
);
   import gti_pkg::*;

   localparam int unsigned PW    = DataWidth + FracWidth + 2;
   localparam int unsigned SW    = PW + 1;
   localparam int unsigned Shift = FracWidth - 1;
   localparam logic signed [SW-1:0] ValHi =
      {{(SW - DataWidth + 1){1'b0}}, {(DataWidth - 1){1'b1}}};
   localparam logic signed [SW-1:0] ValLo = ~ValHi;
   localparam logic signed [SW-1:0] Half  = SW'(FracHalf);

   logic signed [DataWidth:0] diff;
   logic signed [PW-1:0]      prod_in, prod_ff;
   logic signed [DataWidth-1:0] a_ff;
   logic signed [SW-1:0]      sum, q;

   // Multiply stage
   always_comb begin
      diff    = {lerp_b[DataWidth-1], lerp_b} - {lerp_a[DataWidth-1], lerp_a};
      prod_in = diff * $signed({1'b0, lerp_f});
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= lerp_a;
   end

   // Add, floor shift, saturate
   always_comb begin
      sum = (SW'(a_ff) <<< Shift) + SW'(prod_ff) + Half;
      q   = sum >>> Shift;
      if (q > ValHi) begin
         lerp_y = ValHi[DataWidth-1:0];
      end else if (q < ValLo) begin
         lerp_y = ValLo[DataWidth-1:0];
      end else begin
         lerp_y = q[DataWidth-1:0];
      end
   end

endmodule

>>> src/grid_trilinear_interpolator.sv
// Rectilinear grid interpolator top level: registers, stores, sequencer.
//
//  channel   ports                         handshake
//  request   start, busy, req_*            taken when start & !busy
//  response  rsp_valid, rsp_*              one-cycle strobe, no back-pressure
//  config    csr_valid, csr_ready, csr_*   written when csr_valid & csr_ready
//
// A load is written when it is taken. A query walks each axis in turn: an axis with a
// single point needs no search; an axis with n > 1 points reads its end points and, when
// the point lies inside, may binary-search the cell and run the bit-serial divider. It
// then sets up the corners and gives one result per slot: a valid slot takes eight
// single-port grid reads and seven passes through the one lerp multiplier. busy stays
// high for the whole query; each result leaves through one output register.
// Reset is synchronous and clears control and the configuration registers; stores keep contents.
// Results cannot be stalled.
module grid_trilinear_interpolator #(
   parameter int unsigned AXIS_MAX   = gti_pkg::AxisMaxDefault,
   parameter int unsigned VALUES_MAX = gti_pkg::ValuesMaxDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_axis_select,
   input  logic [3:0]  req_index_x,
   input  logic [3:0]  req_index_y,
   input  logic [3:0]  req_index_z,
   input  logic [2:0]  req_value_slot,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_value_out,
   output logic        rsp_out_of_range,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import gti_pkg::*;

   localparam int unsigned AW = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;
   localparam int unsigned VW = (VALUES_MAX > 1) ? $clog2(VALUES_MAX) : 1;
   localparam int unsigned CW = $clog2(AXIS_MAX + 1);
   localparam int unsigned GA = 3 * AW + VW;
   localparam int unsigned GridDepth = 1 << GA;
   localparam int unsigned AxisDepth = 1 << (AW + 2);
   localparam int unsigned FW = FracWidth;

   typedef enum logic [20:0] {
      S_IDLE     = 21'h000001,
      S_AX_START = 21'h000002,
      S_AX_C0    = 21'h000004,
      S_AX_CN    = 21'h000008,
      S_SR_ADDR  = 21'h000010,
      S_SR_CMP   = 21'h000020,
      S_DIV_INIT = 21'h000040,
      S_DIV_WAIT = 21'h000080,
      S_AX_NEXT  = 21'h000100,
      S_PREP     = 21'h000200,
      S_SLOT     = 21'h000400,
      S_RD_A     = 21'h000800,
      S_RD_B     = 21'h001000,
      S_LX       = 21'h002000,
      S_WX       = 21'h004000,
      S_LY0      = 21'h008000,
      S_WY0      = 21'h010000,
      S_LY1      = 21'h020000,
      S_WY1      = 21'h040000,
      S_LZ       = 21'h080000,
      S_WZ       = 21'h100000
   } state_type;

   // Configuration registers
   logic        q_lin_ff;
   logic [1:0]  sdim_ff;
   logic [4:0]  cnt_x_ff, cnt_y_ff, cnt_z_ff;
   logic [3:0]  vcnt_ff, qcnt_ff;
   logic [23:0] qmap_ff;

   // Sequencer state
   state_type        state_ff, state_in;
   logic [1:0]       ax_ff, ax_in;
   logic [AW-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, mid_w;
   logic signed [31:0] cl_ff, cl_in, cr_ff, cr_in;
   logic signed [31:0] t_ff [3];
   logic signed [31:0] t_in [3];
   logic [AW-1:0]    base_ff [3];
   logic [AW-1:0]    base_in [3];
   logic [AW-1:0]    i1_ff [3];
   logic [AW-1:0]    i1_in [3];
   logic [FW-1:0]    frac_ff [3];
   logic [FW-1:0]    frac_in [3];
   logic [2:0]       oor_ff, oor_in;
   logic [2:0]       k_ff, k_in;
   logic [1:0]       j_ff, j_in;
   logic signed [31:0] ca_ff, ca_in, d0_ff, d0_in, d1_ff, d1_in;
   logic signed [31:0] cor_ff [4];
   logic signed [31:0] cor_in [4];
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic             rsp_oor_ff, rsp_oor_in, rsp_last_ff, rsp_last_in;

   // Stores
   logic signed [31:0] ax_mem [AxisDepth];
   logic signed [31:0] gv_mem [GridDepth];
   logic signed [31:0] ax_rd_ff, gv_rd_ff;
   logic [AW+1:0]    ax_rd_addr, ax_wr_addr;
   logic [GA-1:0]    gv_rd_addr, gv_wr_addr;
   logic             ax_wr, gv_wr;

   // Derived values
   logic [CW-1:0]    n_ax [3];
   logic [CW-1:0]    n_cur;
   logic [1:0]       dims;
   logic [4:0]       nvc;
   logic [3:0]       nq;
   logic signed [31:0] t_cur;
   logic [2:0]       slot_cur;
   logic             k_last;
   logic signed [32:0] num_w, den_w;

   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic signed [31:0] lerp_a, lerp_b, lerp_y;
   logic [FW-1:0]    lerp_f;

   function automatic logic [CW-1:0] eff_axis(input logic [4:0] c);
      if (c == 5'd0) return CW'(1);
      if (32'(c) > AXIS_MAX) return CW'(AXIS_MAX);
      return CW'(c);
   endfunction

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         q_lin_ff <= 1'b0;
         sdim_ff  <= 2'd3;
         cnt_x_ff <= 5'd1;
         cnt_y_ff <= 5'd1;
         cnt_z_ff <= 5'd1;
         vcnt_ff  <= 4'd1;
         qcnt_ff  <= 4'd1;
         qmap_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrQueryLinear: q_lin_ff <= csr_wdata[0];
            CsrSpaceDim:    sdim_ff  <= csr_wdata[1:0];
            CsrCountX:      cnt_x_ff <= csr_wdata[4:0];
            CsrCountY:      cnt_y_ff <= csr_wdata[4:0];
            CsrCountZ:      cnt_z_ff <= csr_wdata[4:0];
            CsrValueCount:  vcnt_ff  <= csr_wdata[3:0];
            CsrQueryCount:  qcnt_ff  <= csr_wdata[3:0];
            CsrQueryMap:    qmap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective counts
   always_comb begin
      dims    = (sdim_ff == 2'd0) ? 2'd1 : sdim_ff;
      n_ax[0] = eff_axis(cnt_x_ff);
      n_ax[1] = (dims >= 2'd2) ? eff_axis(cnt_y_ff) : CW'(1);
      n_ax[2] = (dims == 2'd3) ? eff_axis(cnt_z_ff) : CW'(1);
      if (vcnt_ff == 4'd0) nvc = 5'd1;
      else if (32'(vcnt_ff) > VALUES_MAX) nvc = 5'(VALUES_MAX);
      else nvc = 5'(vcnt_ff);
      if (qcnt_ff == 4'd0) nq = 4'd1;
      else if (32'(qcnt_ff) > QueryMax) nq = 4'(QueryMax);
      else nq = qcnt_ff;
      n_cur    = n_ax[ax_ff];
      t_cur    = t_ff[ax_ff];
      slot_cur = qmap_ff[3 * k_ff +: 3];
      k_last   = ((4'(k_ff) + 4'd1) == nq);
      mid_w    = AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
      num_w    = {t_cur[31], t_cur} - {cl_ff[31], cl_ff};
      den_w    = {cr_ff[31], cr_ff} - {cl_ff[31], cl_ff};
   end

   // Load write enables
   always_comb begin
      ax_wr = start && !busy && (req_mode == ModeAxisLoad)
              && (32'(req_axis_select) < AxisCount) && (32'(req_index_x) < AXIS_MAX);
      gv_wr = start && !busy && (req_mode == ModeValueLoad)
              && (32'(req_index_x) < AXIS_MAX) && (32'(req_index_y) < AXIS_MAX)
              && (32'(req_index_z) < AXIS_MAX) && (32'(req_value_slot) < VALUES_MAX);
      ax_wr_addr = {req_axis_select, AW'(req_index_x)};
      gv_wr_addr = {AW'(req_index_z), AW'(req_index_y), AW'(req_index_x),
                    VW'(req_value_slot)};
   end

   // Read addresses
   always_comb begin
      if (state_ff == S_AX_C0) begin
         ax_rd_addr = {ax_ff, AW'(n_cur - CW'(1))};
      end else if (state_ff == S_SR_ADDR) begin
         ax_rd_addr = {ax_ff, mid_w};
      end else begin
         ax_rd_addr = {ax_ff, {AW{1'b0}}};
      end
      gv_rd_addr = {(j_ff[1] ? i1_ff[2] : base_ff[2]),
                    (j_ff[0] ? i1_ff[1] : base_ff[1]),
                    ((state_ff == S_RD_B) ? i1_ff[0] : base_ff[0]),
                    VW'(slot_cur)};
   end

   // Coordinate store
   always_ff @(posedge clock) begin
      if (ax_wr) ax_mem[ax_wr_addr] <= req_coord_x;
      ax_rd_ff <= ax_mem[ax_rd_addr];
   end

   // Grid store
   always_ff @(posedge clock) begin
      if (gv_wr) gv_mem[gv_wr_addr] <= req_sample_value;
      gv_rd_ff <= gv_mem[gv_rd_addr];
   end

   // Lerp operand select
   always_comb begin
      if (state_ff == S_LY0) begin
         lerp_a = cor_ff[0];
         lerp_b = cor_ff[1];
         lerp_f = frac_ff[1];
      end else if (state_ff == S_LY1) begin
         lerp_a = cor_ff[2];
         lerp_b = cor_ff[3];
         lerp_f = frac_ff[1];
      end else if (state_ff == S_LZ) begin
         lerp_a = d0_ff;
         lerp_b = d1_ff;
         lerp_f = frac_ff[2];
      end else begin
         lerp_a = ca_ff;
         lerp_b = gv_rd_ff;
         lerp_f = frac_ff[0];
      end
   end

   gti_lerp u_lerp (
      .clock  (clock),
      .lerp_a (lerp_a),
      .lerp_b (lerp_b),
      .lerp_f (lerp_f),
      .lerp_y (lerp_y)
   );

   // Divider start
   always_comb begin
      div_req.start = (state_ff == S_DIV_INIT) && (t_cur > cl_ff) && (cr_ff > cl_ff)
                      && (num_w[31:0] < den_w[31:0]);
      div_req.num   = num_w[31:0];
      div_req.den   = den_w[31:0];
   end

   gti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cl_in        = cl_ff;
      cr_in        = cr_ff;
      t_in         = t_ff;
      base_in      = base_ff;
      i1_in        = i1_ff;
      frac_in      = frac_ff;
      oor_in       = oor_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      ca_in        = ca_ff;
      cor_in       = cor_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && (req_mode == ModeQuery)) begin
               t_in[0]  = req_coord_x;
               t_in[1]  = req_coord_y;
               t_in[2]  = req_coord_z;
               ax_in    = 2'd0;
               state_in = S_AX_START;
            end
         end
         S_AX_START: begin
            if (n_cur <= CW'(1)) begin
               base_in[ax_ff] = '0;
               frac_in[ax_ff] = '0;
               oor_in[ax_ff]  = 1'b0;
               state_in       = S_AX_NEXT;
            end else begin
               state_in = S_AX_C0;
            end
         end
         S_AX_C0: begin
            cl_in    = ax_rd_ff;
            state_in = S_AX_CN;
         end
         S_AX_CN: begin
            cr_in = ax_rd_ff;
            if ((t_cur < cl_ff) || (t_cur > ax_rd_ff)) begin
               oor_in[ax_ff]  = 1'b1;
               frac_in[ax_ff] = '0;
               base_in[ax_ff] = (t_cur <= cl_ff) ? '0 : AW'(n_cur - CW'(1));
               state_in       = S_AX_NEXT;
            end else begin
               oor_in[ax_ff] = 1'b0;
               lo_in         = '0;
               hi_in         = AW'(n_cur - CW'(1));
               state_in      = (n_cur > CW'(2)) ? S_SR_ADDR : S_DIV_INIT;
            end
         end
         S_SR_ADDR: begin
            mid_in   = mid_w;
            state_in = S_SR_CMP;
         end
         S_SR_CMP: begin
            if (t_cur < ax_rd_ff) begin
               hi_in    = mid_ff;
               cr_in    = ax_rd_ff;
               state_in = (({1'b0, mid_ff} - {1'b0, lo_ff}) > (AW + 1)'(1))
                          ? S_SR_ADDR : S_DIV_INIT;
            end else begin
               lo_in    = mid_ff;
               cl_in    = ax_rd_ff;
               state_in = (({1'b0, hi_ff} - {1'b0, mid_ff}) > (AW + 1)'(1))
                          ? S_SR_ADDR : S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            base_in[ax_ff] = lo_ff;
            if ((t_cur > cl_ff) && (cr_ff > cl_ff)) begin
               if (num_w[31:0] >= den_w[31:0]) begin
                  frac_in[ax_ff] = FracOne;
                  state_in       = S_AX_NEXT;
               end else begin
                  state_in = S_DIV_WAIT;
               end
            end else begin
               frac_in[ax_ff] = '0;
               state_in       = S_AX_NEXT;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               frac_in[ax_ff] = {1'b0, div_rsp.quo};
               state_in       = S_AX_NEXT;
            end
         end
         S_AX_NEXT: begin
            if (ax_ff == 2'd2) begin
               state_in = S_PREP;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_AX_START;
            end
         end
         S_PREP: begin
            // Corner indices and weights per axis
            for (int a = 0; a < 3; a++) begin
               if (q_lin_ff) begin
                  i1_in[a] = (n_ax[a] > CW'(1)) ? base_ff[a] + AW'(1) : base_ff[a];
               end else begin
                  if (!oor_ff[a] && (frac_ff[a] >= FracHalf)
                      && ((32'(base_ff[a]) + 32'd1) < 32'(n_ax[a]))) begin
                     base_in[a] = base_ff[a] + AW'(1);
                     i1_in[a]   = base_ff[a] + AW'(1);
                  end else begin
                     i1_in[a] = base_ff[a];
                  end
                  frac_in[a] = '0;
               end
            end
            if (q_lin_ff && (oor_ff != 3'b000)) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_oor_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               k_in     = '0;
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            if (5'(slot_cur) < nvc) begin
               j_in     = '0;
               state_in = S_RD_A;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_oor_in   = 1'b0;
               rsp_last_in  = k_last;
               k_in         = k_ff + 3'd1;
               state_in     = k_last ? S_IDLE : S_SLOT;
            end
         end
         S_RD_A: state_in = S_RD_B;
         S_RD_B: begin
            ca_in    = gv_rd_ff;
            state_in = S_LX;
         end
         S_LX: state_in = S_WX;
         S_WX: begin
            cor_in[j_ff] = lerp_y;
            j_in         = j_ff + 2'd1;
            state_in     = (j_ff == 2'd3) ? S_LY0 : S_RD_A;
         end
         S_LY0: state_in = S_WY0;
         S_WY0: begin
            d0_in    = lerp_y;
            state_in = S_LY1;
         end
         S_LY1: state_in = S_WY1;
         S_WY1: begin
            d1_in    = lerp_y;
            state_in = S_LZ;
         end
         S_LZ: state_in = S_WZ;
         S_WZ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = lerp_y;
            rsp_oor_in   = 1'b0;
            rsp_last_in  = k_last;
            k_in         = k_ff + 3'd1;
            state_in     = k_last ? S_IDLE : S_SLOT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      cl_ff        <= cl_in;
      cr_ff        <= cr_in;
      t_ff         <= t_in;
      base_ff      <= base_in;
      i1_ff        <= i1_in;
      frac_ff      <= frac_in;
      oor_ff       <= oor_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      ca_ff        <= ca_in;
      cor_ff       <= cor_in;
      d0_ff        <= d0_in;
      d1_ff        <= d1_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> src/gti_checker.sv
// Port-level checks for the grid trilinear interpolator, bound to the top level.
module gti_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic signed [31:0] rsp_value_out,
   input logic        rsp_out_of_range,
   input logic        rsp_last
);
   import gti_pkg::*;

   // Loads and ignored modes finish in the cycle they are taken
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode != ModeQuery)) |=> !busy)
      else $error("load left the block busy");

   // A query holds the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == ModeQuery)) |=> busy)
      else $error("query did not raise busy");

   // The final item of a query frees the block, earlier ones do not
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy after final item");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("idle before final item");

   // Out-of-range item is a lone zero
   a_oor_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_last && (rsp_value_out == 32'sd0)))
      else $error("malformed out-of-range item");

endmodule

bind grid_trilinear_interpolator gti_checker u_gti_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_value_out    (rsp_value_out),
   .rsp_out_of_range (rsp_out_of_range),
   .rsp_last         (rsp_last)
);

>>> test/grid_trilinear_interpolator_checker.sv
// Watches the interpolator channels, predicts each query's results and compares them.
`timescale 1ns / 1ps
module grid_trilinear_interpolator_checker
   import gti_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_axis_select,
   input  logic [3:0]         req_index_x,
   input  logic [3:0]         req_index_y,
   input  logic [3:0]         req_index_z,
   input  logic [2:0]         req_value_slot,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_value_out,
   input  logic               rsp_out_of_range,
   input  logic               rsp_last,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   localparam int AxisDepth = 16;
   localparam int SlotDepth = 8;
   localparam longint ValHi = 64'sd2147483647;
   localparam longint ValLo = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] value;
      logic               oor;
      logic               last;
   } sample_result_t;

   sample_result_t     expected_q[$];
   logic signed [31:0] axis_mem [0:3*AxisDepth-1];
   logic signed [31:0] grid_mem [0:AxisDepth*AxisDepth*AxisDepth*SlotDepth-1];

   // shadow of the register file
   logic        linear_mode;
   logic [1:0]  dim_reg;
   logic [4:0]  cnt_reg [3];
   logic [3:0]  vcount_reg;
   logic [3:0]  qcount_reg;
   logic [23:0] map_reg;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int clamp_count(input int v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic longint saturate(input longint v);
      if (v > ValHi) return ValHi;
      if (v < ValLo) return ValLo;
      return v;
   endfunction

   function automatic longint blend(input longint a, input longint b, input int unsigned f);
      longint q;
      q = a * (65536 - longint'(f)) + b * longint'(f) + 32768;
      if (q >= 0) return saturate(q >>> 16);
      return saturate(-((-q + 65535) >>> 16));
   endfunction

   function automatic longint grid_at(input int x, input int y, input int z, input int s);
      return longint'(grid_mem[((z * AxisDepth + y) * AxisDepth + x) * SlotDepth + s]);
   endfunction

   // binary search on one axis: base cell, Q1.16 fraction, outside flag
   task automatic locate_axis(input int a, input int n, input longint t,
                              output int base, output int unsigned frac, output bit oor);
      longint c0, cn, cl, cr;
      int lo, hi, mid;
      longint unsigned num, den;
      base = 0;
      frac = 0;
      oor  = 0;
      if (n > 1) begin
         c0 = longint'(axis_mem[a*AxisDepth]);
         cn = longint'(axis_mem[a*AxisDepth + n - 1]);
         if (t >= c0 && t <= cn) begin
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
               mid = lo + (hi - lo) / 2;
               if (t < longint'(axis_mem[a*AxisDepth + mid])) hi = mid;
               else lo = mid;
            end
            cl = longint'(axis_mem[a*AxisDepth + lo]);
            cr = longint'(axis_mem[a*AxisDepth + hi]);
            base = lo;
            if (t > cl && cr > cl) begin
               num = longint'(t - cl);
               den = longint'(cr - cl);
               frac = (num >= den) ? 65536 : int'((num << 16) / den);
            end
         end else begin
            oor  = 1;
            base = (t <= c0) ? 0 : n - 1;
         end
      end
   endtask

   // expected results of one query
   task automatic predict_query(input longint tx, input longint ty, input longint tz);
      int dims, nvc, nq, s;
      int n[3], base[3], i0[3], i1[3];
      int unsigned fr[3];
      bit oor[3];
      bit any_oor;
      longint t[3];
      longint c00, c10, c01, c11, v;
      sample_result_t r;
      t[0] = tx;
      t[1] = ty;
      t[2] = tz;
      any_oor = 0;
      dims = (dim_reg == 0) ? 1 : int'(dim_reg);
      nvc  = clamp_count(int'(vcount_reg), SlotDepth);
      nq   = clamp_count(int'(qcount_reg), QueryMax);
      for (int a = 0; a < 3; a++) begin
         n[a] = (a >= dims) ? 1 : clamp_count(int'(cnt_reg[a]), AxisDepth);
         locate_axis(a, n[a], t[a], base[a], fr[a], oor[a]);
         if (oor[a]) any_oor = 1;
      end
      if (linear_mode && any_oor) begin
         r.value = '0;
         r.oor   = 1'b1;
         r.last  = 1'b1;
         expected_q.push_back(r);
         return;
      end
      for (int a = 0; a < 3; a++) begin
         if (linear_mode) begin
            i0[a] = base[a];
            i1[a] = (n[a] > 1) ? base[a] + 1 : base[a];
         end else begin
            // nearest: round up from half way, never past the last point
            i0[a] = base[a];
            if (!oor[a] && fr[a] >= 32768 && base[a] + 1 < n[a]) i0[a] = base[a] + 1;
            i1[a] = i0[a];
            fr[a] = 0;
         end
      end
      for (int k = 0; k < nq; k++) begin
         s = int'((map_reg >> (3 * k)) & 24'd7);
         v = 0;
         if (s < nvc) begin
            c00 = blend(grid_at(i0[0], i0[1], i0[2], s), grid_at(i1[0], i0[1], i0[2], s), fr[0]);
            c10 = blend(grid_at(i0[0], i1[1], i0[2], s), grid_at(i1[0], i1[1], i0[2], s), fr[0]);
            c01 = blend(grid_at(i0[0], i0[1], i1[2], s), grid_at(i1[0], i0[1], i1[2], s), fr[0]);
            c11 = blend(grid_at(i0[0], i1[1], i1[2], s), grid_at(i1[0], i1[1], i1[2], s), fr[0]);
            v = blend(blend(c00, c10, fr[1]), blend(c01, c11, fr[1]), fr[2]);
         end
         r.value = v[31:0];
         r.oor   = 1'b0;
         r.last  = (k + 1 == nq);
         expected_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      sample_result_t e;
      if (reset) begin
         linear_mode = 1'b0;
         dim_reg     = 2'd3;
         cnt_reg[0]  = 5'd1;
         cnt_reg[1]  = 5'd1;
         cnt_reg[2]  = 5'd1;
         vcount_reg  = 4'd1;
         qcount_reg  = 4'd1;
         map_reg     = '0;
         fail_count  = 0;
         expected_q.delete();
      end else begin
         // results first: none can belong to an item taken at this edge
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result, value", rsp_value_out, 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_value_out !== e.value)
                  report_mismatch("value_out", rsp_value_out, e.value);
               if (rsp_out_of_range !== e.oor)
                  report_mismatch("out_of_range", rsp_out_of_range, e.oor);
               if (rsp_last !== e.last)
                  report_mismatch("last", rsp_last, e.last);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrQueryLinear: linear_mode = csr_wdata[0];
               CsrSpaceDim:    dim_reg     = csr_wdata[1:0];
               CsrCountX:      cnt_reg[0]  = csr_wdata[4:0];
               CsrCountY:      cnt_reg[1]  = csr_wdata[4:0];
               CsrCountZ:      cnt_reg[2]  = csr_wdata[4:0];
               CsrValueCount:  vcount_reg  = csr_wdata[3:0];
               CsrQueryCount:  qcount_reg  = csr_wdata[3:0];
               CsrQueryMap:    map_reg     = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_mode)
               ModeAxisLoad:
                  if (req_axis_select < 2'd3)
                     axis_mem[int'(req_axis_select)*AxisDepth + int'(req_index_x)] = req_coord_x;
               ModeValueLoad:
                  grid_mem[((int'(req_index_z) * AxisDepth + int'(req_index_y)) * AxisDepth
                            + int'(req_index_x)) * SlotDepth + int'(req_value_slot)]
                     = req_sample_value;
               ModeQuery:
                  predict_query(longint'(req_coord_x), longint'(req_coord_y),
                                longint'(req_coord_z));
               default: ;
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> test/grid_trilinear_interpolator_tb.sv
// Stimulus and verdict for the grid trilinear interpolator, checked by a side-by-side checker.
`timescale 1ns / 1ps
module grid_trilinear_interpolator_tb;
   import gti_pkg::*;

   localparam logic [1:0] ModeIgnored = 2'd3;
   localparam logic [1:0] AxisNone    = 2'd3;
   localparam int         CycleLimit  = 200000;
   localparam int         ItemTarget  = 160;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_mode;
   logic [1:0]         req_axis_select;
   logic [3:0]         req_index_x;
   logic [3:0]         req_index_y;
   logic [3:0]         req_index_z;
   logic [2:0]         req_value_slot;
   logic signed [31:0] req_sample_value;
   logic signed [31:0] req_coord_x;
   logic signed [31:0] req_coord_y;
   logic signed [31:0] req_coord_z;
   logic               rsp_valid;
   logic signed [31:0] rsp_value_out;
   logic               rsp_out_of_range;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [23:0]        csr_wdata;
   int                 fail_count;
   int                 pending;
   int                 cycle_count = 0;

   // current settings, as the stimulus sees them
   int     cur_dim, cur_cnt[3], cur_vc;
   longint axis_tab[3][16];
   bit     calm;
   int     items_sent;

   grid_trilinear_interpolator u_top (.*);

   grid_trilinear_interpolator_checker u_checker (.*);

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int eff_count(input int v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // present one item and hold it until taken
   task automatic issue_item(input logic [1:0] m, input logic [1:0] ax,
                             input logic [3:0] ix, input logic [3:0] iy, input logic [3:0] iz,
                             input logic [2:0] slot, input logic [31:0] sv,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      start            <= 1'b1;
      req_mode         <= m;
      req_axis_select  <= ax;
      req_index_x      <= ix;
      req_index_y      <= iy;
      req_index_z      <= iz;
      req_value_slot   <= slot;
      req_sample_value <= sv;
      req_coord_x      <= cx;
      req_coord_y      <= cy;
      req_coord_z      <= cz;
      // busy only moves at the rising edge, so it is steady here
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int lin, input int dim, input int cx, input int cy,
                            input int cz, input int vc, input int qc, input logic [23:0] qmap);
      csr_write(CsrQueryLinear, 24'(lin));
      csr_write(CsrSpaceDim, 24'(dim));
      csr_write(CsrCountX, 24'(cx));
      csr_write(CsrCountY, 24'(cy));
      csr_write(CsrCountZ, 24'(cz));
      csr_write(CsrValueCount, 24'(vc));
      csr_write(CsrQueryCount, 24'(qc));
      csr_write(CsrQueryMap, qmap);
      cur_dim = (dim == 0) ? 1 : dim;
      cur_cnt[0] = eff_count(cx, 16);
      cur_cnt[1] = eff_count(cy, 16);
      cur_cnt[2] = eff_count(cz, 16);
      cur_vc = eff_count(vc, 8);
      for (int a = 0; a < 3; a++)
         if (a >= cur_dim) cur_cnt[a] = 1;
   endtask

   function automatic logic [31:0] grid_sample();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 131071)) - 32'd65536;
         default: return $urandom;
      endcase
   endfunction

   // axis lists (0 ascending, 1 scrambled with repeats, 2 the full range)
   // and every grid entry that a query can reach
   task automatic load_tables(input int order);
      longint c;
      for (int a = 0; a < 3; a++) begin
         if (cur_cnt[a] > 1) begin
            c = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            for (int i = 0; i < cur_cnt[a]; i++) begin
               if (order == 2) c = (i == 0) ? -64'sd2147483648 : 64'sd2147483647;
               else if (order == 1) c = ($urandom_range(0, 3) == 0 && i > 0) ? c :
                                        longint'($urandom_range(0, 1 << 20)) - (1 << 19);
               else if (i > 0) c = c + longint'($urandom_range(1, 1 << 20));
               axis_tab[a][i] = c;
               issue_item(ModeAxisLoad, 2'(a), 4'(i), 4'($urandom), 4'($urandom),
                          3'($urandom), $urandom, 32'(c), $urandom, $urandom);
            end
         end
      end
      for (int z = 0; z < cur_cnt[2]; z++)
         for (int y = 0; y < cur_cnt[1]; y++)
            for (int x = 0; x < cur_cnt[0]; x++)
               for (int s = 0; s < cur_vc; s++)
                  issue_item(ModeValueLoad, 2'($urandom), 4'(x), 4'(y), 4'(z), 3'(s),
                             grid_sample(), $urandom, $urandom, $urandom);
   endtask

   // items the block must ignore, and stray loads anywhere in the grid
   task automatic send_noise();
      issue_item(ModeIgnored, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                 3'($urandom), $urandom, $urandom, $urandom, $urandom);
      issue_item(ModeAxisLoad, AxisNone, 4'($urandom), 4'($urandom), 4'($urandom),
                 3'($urandom), $urandom, $urandom, $urandom, $urandom);
      issue_item(ModeValueLoad, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                 3'($urandom), grid_sample(), $urandom, $urandom, $urandom);
   endtask

   function automatic logic [31:0] pick_coord(input int a);
      longint lo, hi, c;
      longint unsigned r64;
      int n;
      n = cur_cnt[a];
      if (n <= 1) return $urandom;
      lo = axis_tab[a][0];
      hi = axis_tab[a][n-1];
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'(axis_tab[a][$urandom_range(0, n - 1)]);
         2: begin
            c = $urandom_range(0, 1) ? lo - 1 : hi + 1;
            if (c < -64'sd2147483648 || c > 64'sd2147483647) return $urandom;
            return 32'(c);
         end
         default: begin
            if (hi < lo) return 32'(lo);
            r64 = {$urandom, $urandom};
            return 32'(lo + longint'(r64 % longint'(hi - lo + 1)));
         end
      endcase
   endfunction

   task automatic send_query();
      issue_item(ModeQuery, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                 3'($urandom), $urandom, pick_coord(0), pick_coord(1), pick_coord(2));
   endtask

   task automatic run_phase(input int lin, input int dim, input int cx, input int cy,
                            input int cz, input int vc, input int qc,
                            input logic [23:0] qmap, input int order, input int nq);
      configure(lin, dim, cx, cy, cz, vc, qc, qmap);
      load_tables(order);
      send_noise();
      repeat (nq) send_query();
   endtask

   initial begin
      int lin, dim, cx, cy, cz;
      reset = 1'b1;
      start = 1'b0;
      req_mode = ModeAxisLoad;
      req_axis_select = '0;
      req_index_x = '0;
      req_index_y = '0;
      req_index_z = '0;
      req_value_slot = '0;
      req_sample_value = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      items_sent = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: one grid point, nearest, plain read
      cur_dim = 3;
      cur_cnt = '{1, 1, 1};
      cur_vc = 1;
      issue_item(ModeValueLoad, 2'd0, 4'd0, 4'd0, 4'd0, 3'd0, 32'h7FFF_FFFF,
                 '0, '0, '0);
      send_noise();
      send_query();
      send_query();

      // full range axis: exact ends, middle, and the slots beyond value_count
      configure(1, 1, 2, 1, 1, 1, 8, 24'o76543210);
      load_tables(2);
      issue_item(ModeQuery, '0, '0, '0, '0, '0, '0, 32'h8000_0000, '0, '0);
      issue_item(ModeQuery, '0, '0, '0, '0, '0, '0, 32'h7FFF_FFFF, '0, '0);
      issue_item(ModeQuery, '0, '0, '0, '0, '0, '0, 32'h0000_0000, '0, '0);

      // counts beyond their ranges, widest axis on x, no idling
      calm = 1'b1;
      run_phase(1, 0, 31, 0, 0, 0, 15, 24'o70707070, 0, 4);
      calm = 1'b0;
      // nearest, value_count beyond its range, all eight values
      run_phase(0, 1, 2, 1, 1, 15, 8, 24'o01234567, 0, 4);
      // scrambled and repeated coordinates
      run_phase(1, 1, 5, 1, 1, 1, 1, 24'o0, 1, 5);
      // bilinear and trilinear, nearest three-axis
      run_phase(1, 2, 3, 2, 1, 1, 2, 24'o10, 0, 4);
      run_phase(1, 3, 2, 2, 2, 1, 1, 24'o0, 0, 4);
      run_phase(0, 3, 2, 2, 2, 1, 1, 24'o0, 0, 4);

      // small random settings until enough items have gone
      while (items_sent < ItemTarget) begin
         lin = $urandom_range(0, 1);
         dim = $urandom_range(0, 3);
         cx = $urandom_range(1, 3);
         cy = $urandom_range(1, 3);
         cz = $urandom_range(1, 2);
         run_phase(lin, dim, cx, cy, cz, $urandom_range(1, 2), $urandom_range(1, 8),
                   24'($urandom), ($urandom_range(0, 5) == 0) ? 1 : 0,
                   $urandom_range(3, 6));
      end

      // drain, then let the block settle
      wait_idle();
      repeat (300) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
